[rtl/cskc_pkg.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// cskc_pkg
// Shared types, codes and widths of the clock set keypad controller.
// ----------------------------------------------------------------------------
package cskc_pkg;

	localparam int YEAR_W   = 7;
	localparam int MONTH_W  = 4;
	localparam int DATE_W   = 5;
	localparam int HOUR_W   = 5;
	localparam int MINUTE_W = 6;
	localparam int SECOND_W = 6;
	localparam int TIMER_W  = 8;
	localparam int RPT_W    = 3;

	localparam int APB_AW = 5;
	localparam int APB_DW = 32;

	localparam logic [HOUR_W-1:0]   HOUR_MAX    = HOUR_W'(12);
	localparam logic [HOUR_W-1:0]   HOUR_MIN    = HOUR_W'(1);
	localparam logic [HOUR_W-1:0]   HOUR_VALID  = HOUR_W'(23);
	localparam logic [MINUTE_W-1:0] MINUTE_MAX  = MINUTE_W'(59);
	localparam logic [SECOND_W-1:0] SECOND_MAX  = SECOND_W'(59);
	localparam logic [MONTH_W-1:0]  MONTH_MAX   = MONTH_W'(12);

	typedef enum logic {
		OP_TICK  = 1'b0,
		OP_START = 1'b1
	} opcode_t;

	typedef enum logic [1:0] {
		STEP_HOUR   = 2'd0,
		STEP_MINUTE = 2'd1,
		STEP_FINISH = 2'd2
	} step_t;

	typedef enum logic [1:0] {
		HOLD_KEEP    = 2'd0,
		HOLD_MINUS   = 2'd1,
		HOLD_PLUS    = 2'd2,
		HOLD_RELEASE = 2'd3
	} hold_req_t;

	typedef enum logic [1:0] {
		KEY_NONE  = 2'd0,
		KEY_MINUS = 2'd1,
		KEY_PLUS  = 2'd2
	} held_key_t;

	typedef enum logic [2:0] {
		REG_MIN_YEAR      = 3'd0,
		REG_MAX_YEAR      = 3'd1,
		REG_TIMEOUT_TICKS = 3'd2,
		REG_FINISH_DELAY  = 3'd3,
		REG_REPEAT_CAP    = 3'd4
	} reg_index_t;

	typedef struct packed {
		logic [YEAR_W-1:0]  min_year;
		logic [YEAR_W-1:0]  max_year;
		logic [TIMER_W-1:0] timeout_ticks;
		logic [TIMER_W-1:0] finish_delay;
		logic [TIMER_W-1:0] repeat_cap;
	} cfg_t;

	typedef struct packed {
		opcode_t             opcode;
		logic                minus_press;
		logic                plus_press;
		logic                switch_press;
		hold_req_t           hold_request;
		logic [YEAR_W-1:0]   clock_year;
		logic [MONTH_W-1:0]  clock_month;
		logic [DATE_W-1:0]   clock_date;
		logic [HOUR_W-1:0]   clock_hour;
		logic [MINUTE_W-1:0] clock_minute;
		logic [SECOND_W-1:0] clock_second;
	} cmd_t;

	typedef struct packed {
		logic                active;
		step_t               edit_step;
		logic [HOUR_W-1:0]   hour_value;
		logic [MINUTE_W-1:0] minute_value;
		logic                commit;
		logic [YEAR_W-1:0]   year_value;
		logic [MONTH_W-1:0]  month_value;
		logic [DATE_W-1:0]   date_value;
		logic [SECOND_W-1:0] second_value;
		logic                first_set_done;
	} res_t;

	typedef struct packed {
		logic                active;
		step_t               step;
		logic [YEAR_W-1:0]   year;
		logic [MONTH_W-1:0]  month;
		logic [DATE_W-1:0]   date;
		logic [HOUR_W-1:0]   hour;
		logic [MINUTE_W-1:0] minute;
		logic [SECOND_W-1:0] second;
		logic [TIMER_W-1:0]  idle_timer;
		logic [TIMER_W-1:0]  finish_timer;
		logic [RPT_W-1:0]    repeat_timer;
		logic [TIMER_W-1:0]  repeat_count;
		held_key_t           held_key;
		logic                first_done;
	} state_t;

endpackage

[rtl/cskc_if.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// cskc_if
// Valid/ready channels for command items and result items.
// ----------------------------------------------------------------------------
interface cskc_cmd_if;
	logic                          valid;
	logic                          ready;
	logic                          opcode;
	logic                          minus_press;
	logic                          plus_press;
	logic                          switch_press;
	logic [1:0]                    hold_request;
	logic [cskc_pkg::YEAR_W-1:0]   clock_year;
	logic [cskc_pkg::MONTH_W-1:0]  clock_month;
	logic [cskc_pkg::DATE_W-1:0]   clock_date;
	logic [cskc_pkg::HOUR_W-1:0]   clock_hour;
	logic [cskc_pkg::MINUTE_W-1:0] clock_minute;
	logic [cskc_pkg::SECOND_W-1:0] clock_second;

	modport source (
		output valid, opcode, minus_press, plus_press, switch_press, hold_request,
		output clock_year, clock_month, clock_date, clock_hour, clock_minute,
		output clock_second,
		input  ready
	);
	modport sink (
		input  valid, opcode, minus_press, plus_press, switch_press, hold_request,
		input  clock_year, clock_month, clock_date, clock_hour, clock_minute,
		input  clock_second,
		output ready
	);
endinterface

interface cskc_res_if;
	logic                          valid;
	logic                          ready;
	logic                          active;
	logic [1:0]                    edit_step;
	logic [cskc_pkg::HOUR_W-1:0]   hour_value;
	logic [cskc_pkg::MINUTE_W-1:0] minute_value;
	logic                          commit;
	logic [cskc_pkg::YEAR_W-1:0]   year_value;
	logic [cskc_pkg::MONTH_W-1:0]  month_value;
	logic [cskc_pkg::DATE_W-1:0]   date_value;
	logic [cskc_pkg::SECOND_W-1:0] second_value;
	logic                          first_set_done;

	modport source (
		output valid, active, edit_step, hour_value, minute_value, commit,
		output year_value, month_value, date_value, second_value, first_set_done,
		input  ready
	);
	modport sink (
		input  valid, active, edit_step, hour_value, minute_value, commit,
		input  year_value, month_value, date_value, second_value, first_set_done,
		output ready
	);
endinterface

[rtl/cskc_cfg_regs.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// cskc_cfg_regs
// APB register file holding the year range, timeout, finish delay and
// repeat cap.
// ----------------------------------------------------------------------------
module cskc_cfg_regs (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        psel,
	input  logic                        penable,
	input  logic                        pwrite,
	input  logic [cskc_pkg::APB_AW-1:0] paddr,
	input  logic [cskc_pkg::APB_DW-1:0] pwdata,
	output logic [cskc_pkg::APB_DW-1:0] prdata,
	output logic                        pready,
	output cskc_pkg::cfg_t              cfg
);
	import cskc_pkg::*;

	cfg_t       cfg_q;
	reg_index_t idx;
	logic       wr_en;

	assign pready = 1'b1;
	assign idx    = reg_index_t'(paddr[APB_AW-1:2]);
	assign wr_en  = psel && penable && pwrite && pready;
	assign cfg    = cfg_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.min_year      <= YEAR_W'(0);
			cfg_q.max_year      <= YEAR_W'(99);
			cfg_q.timeout_ticks <= TIMER_W'(100);
			cfg_q.finish_delay  <= TIMER_W'(10);
			cfg_q.repeat_cap    <= TIMER_W'(60);
		end else if (wr_en) begin
			unique case (idx)
				REG_MIN_YEAR:      cfg_q.min_year      <= pwdata[YEAR_W-1:0];
				REG_MAX_YEAR:      cfg_q.max_year      <= pwdata[YEAR_W-1:0];
				REG_TIMEOUT_TICKS: cfg_q.timeout_ticks <= pwdata[TIMER_W-1:0];
				REG_FINISH_DELAY:  cfg_q.finish_delay  <= pwdata[TIMER_W-1:0];
				REG_REPEAT_CAP:    cfg_q.repeat_cap    <= pwdata[TIMER_W-1:0];
				default: ;
			endcase
		end
	end

	always_comb begin
		unique case (idx)
			REG_MIN_YEAR:      prdata = APB_DW'(cfg_q.min_year);
			REG_MAX_YEAR:      prdata = APB_DW'(cfg_q.max_year);
			REG_TIMEOUT_TICKS: prdata = APB_DW'(cfg_q.timeout_ticks);
			REG_FINISH_DELAY:  prdata = APB_DW'(cfg_q.finish_delay);
			REG_REPEAT_CAP:    prdata = APB_DW'(cfg_q.repeat_cap);
			default:           prdata = '0;
		endcase
	end

endmodule

[rtl/cskc_core.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// cskc_core
// Setting-mode state registers and the next-state logic for one item.
// ----------------------------------------------------------------------------
module cskc_core (
	input  logic           clk,
	input  logic           arst_n,
	input  cskc_pkg::cfg_t cfg,
	input  logic           take,
	input  cskc_pkg::cmd_t cmd,
	output cskc_pkg::res_t res
);
	import cskc_pkg::*;

	state_t st_q;
	state_t st_d;
	logic   commit;

	always_comb begin
		state_t           s;
		logic             minus;
		logic             plus;
		logic             finished;
		logic [RPT_W-1:0] period;

		s        = st_q;
		minus    = cmd.minus_press;
		plus     = cmd.plus_press;
		finished = 1'b0;
		commit   = 1'b0;
		period   = RPT_W'(5);

		if (cmd.opcode == OP_START) begin
			s.active = 1'b1;
			s.step   = STEP_HOUR;
			s.year   = cmd.clock_year;
			s.month  = cmd.clock_month;
			s.date   = cmd.clock_date;
			s.hour   = cmd.clock_hour;
			s.minute = cmd.clock_minute;
			s.second = cmd.clock_second;
		end else begin
			unique case (cmd.hold_request)
				HOLD_MINUS:   s.held_key = KEY_MINUS;
				HOLD_PLUS:    s.held_key = KEY_PLUS;
				HOLD_RELEASE: s.held_key = KEY_NONE;
				default: ;
			endcase

			if (s.active) begin
				s.idle_timer = s.idle_timer + TIMER_W'(1);
				if (s.idle_timer >= cfg.timeout_ticks) begin
					s.idle_timer = '0;
					s.active     = 1'b0;
					s.step       = STEP_HOUR;
				end
			end else begin
				s.idle_timer = '0;
			end

			if (!s.active) begin
				s.held_key     = KEY_NONE;
				s.repeat_timer = '0;
				s.repeat_count = '0;
			end else begin
				if (s.repeat_count >= cfg.repeat_cap) begin
					s.repeat_count = '0;
					s.held_key     = KEY_NONE;
				end
				priority if (s.repeat_count <= TIMER_W'(1)) period = RPT_W'(5);
				else if (s.repeat_count <= TIMER_W'(3)) period = RPT_W'(4);
				else if (s.repeat_count <= TIMER_W'(5)) period = RPT_W'(3);
				else period = RPT_W'(2);

				if (s.held_key == KEY_MINUS || s.held_key == KEY_PLUS) begin
					s.repeat_timer = s.repeat_timer + RPT_W'(1);
					if (s.repeat_timer >= period) begin
						s.repeat_timer = '0;
						if (s.held_key == KEY_MINUS) minus = 1'b1;
						else plus = 1'b1;
						s.repeat_count = s.repeat_count + TIMER_W'(1);
					end
					s.idle_timer = '0;
				end else begin
					s.held_key     = KEY_NONE;
					s.repeat_timer = '0;
					s.repeat_count = '0;
				end

				// A step key in the finish step sends editing back to the hour.
				if (minus) begin
					unique case (s.step)
						STEP_HOUR:
							s.hour = (s.hour > HOUR_MIN) ? s.hour - HOUR_W'(1) : HOUR_MAX;
						STEP_MINUTE:
							s.minute = (s.minute > '0) ? s.minute - MINUTE_W'(1)
							                           : MINUTE_MAX;
						default: s.step = STEP_HOUR;
					endcase
				end
				if (plus) begin
					unique case (s.step)
						STEP_HOUR:
							s.hour = (s.hour < HOUR_MAX) ? s.hour + HOUR_W'(1) : HOUR_MIN;
						STEP_MINUTE:
							s.minute = (s.minute < MINUTE_MAX) ? s.minute + MINUTE_W'(1)
							                                   : '0;
						default: s.step = STEP_HOUR;
					endcase
				end
				if (cmd.switch_press)
					s.step = (s.step == STEP_HOUR) ? STEP_MINUTE : STEP_FINISH;

				if (s.step == STEP_FINISH) begin
					s.finish_timer = s.finish_timer + TIMER_W'(1);
					if (s.finish_timer >= cfg.finish_delay) begin
						s.finish_timer = '0;
						s.active       = 1'b0;
						s.step         = STEP_HOUR;
						finished       = 1'b1;
					end
				end

				if (finished) begin
					s.first_done = 1'b1;
					commit = (s.year >= cfg.min_year) && (s.year <= cfg.max_year) &&
					         (s.month >= MONTH_W'(1)) && (s.month <= MONTH_MAX) &&
					         (s.date >= DATE_W'(1)) && (s.hour <= HOUR_VALID) &&
					         (s.minute <= MINUTE_MAX) && (s.second <= SECOND_MAX);
				end
			end
		end

		st_d = s;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			st_q <= '0;
		end else if (take) begin
			st_q <= st_d;
		end
	end

	always_comb begin
		res.active         = st_d.active;
		res.edit_step      = st_d.step;
		res.hour_value     = st_d.hour;
		res.minute_value   = st_d.minute;
		res.commit         = commit;
		res.year_value     = st_d.year;
		res.month_value    = st_d.month;
		res.date_value     = st_d.date;
		res.second_value   = st_d.second;
		res.first_set_done = st_d.first_done;
	end

endmodule

[rtl/clock_set_keypad_controller_unit.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// clock_set_keypad_controller_unit
// Keypad controller for setting the hour and minute of a clock.
// ----------------------------------------------------------------------------
// The block takes one command item per clock cycle and returns exactly one
// result item for each, in the cycle after acceptance. All per-item work is a
// single pass of compare and increment logic from the state registers into
// the result register, so the rate is one item per cycle; it drops only while
// the result register holds an item that the sink has not yet taken.
// Configuration registers sit on the APB port at byte addresses 0, 4, 8, 12
// and 16 and should be written only while no item is in flight.
module clock_set_keypad_controller_unit (
	input  logic                        clk,
	input  logic                        arst_n,
	cskc_cmd_if.sink                    cmd,
	cskc_res_if.source                  result,
	input  logic                        psel,
	input  logic                        penable,
	input  logic                        pwrite,
	input  logic [cskc_pkg::APB_AW-1:0] paddr,
	input  logic [cskc_pkg::APB_DW-1:0] pwdata,
	output logic [cskc_pkg::APB_DW-1:0] prdata,
	output logic                        pready
);
	import cskc_pkg::*;

	cfg_t cfg;
	cmd_t cmd_item;
	res_t res_next;
	res_t res_q;
	logic valid_q;
	logic take;

	cskc_cfg_regs u_cfg (
		.clk     (clk),
		.arst_n  (arst_n),
		.psel    (psel),
		.penable (penable),
		.pwrite  (pwrite),
		.paddr   (paddr),
		.pwdata  (pwdata),
		.prdata  (prdata),
		.pready  (pready),
		.cfg     (cfg)
	);

	always_comb begin
		cmd_item.opcode       = opcode_t'(cmd.opcode);
		cmd_item.minus_press  = cmd.minus_press;
		cmd_item.plus_press   = cmd.plus_press;
		cmd_item.switch_press = cmd.switch_press;
		cmd_item.hold_request = hold_req_t'(cmd.hold_request);
		cmd_item.clock_year   = cmd.clock_year;
		cmd_item.clock_month  = cmd.clock_month;
		cmd_item.clock_date   = cmd.clock_date;
		cmd_item.clock_hour   = cmd.clock_hour;
		cmd_item.clock_minute = cmd.clock_minute;
		cmd_item.clock_second = cmd.clock_second;
	end

	// The result register frees up in the same cycle that its item is taken.
	assign cmd.ready = !valid_q || result.ready;
	assign take      = cmd.valid && cmd.ready;

	cskc_core u_core (
		.clk    (clk),
		.arst_n (arst_n),
		.cfg    (cfg),
		.take   (take),
		.cmd    (cmd_item),
		.res    (res_next)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else if (cmd.ready) begin
			valid_q <= cmd.valid;
		end
	end

	always_ff @(posedge clk) begin
		if (take) begin
			res_q <= res_next;
		end
	end

	assign result.valid          = valid_q;
	assign result.active         = res_q.active;
	assign result.edit_step      = res_q.edit_step;
	assign result.hour_value     = res_q.hour_value;
	assign result.minute_value   = res_q.minute_value;
	assign result.commit         = res_q.commit;
	assign result.year_value     = res_q.year_value;
	assign result.month_value    = res_q.month_value;
	assign result.date_value     = res_q.date_value;
	assign result.second_value   = res_q.second_value;
	assign result.first_set_done = res_q.first_set_done;

endmodule
